FILE: rtl/cfwf_pkg.sv
package cfwf_pkg;

    // Field widths
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned LEN_W       = 9;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    // CRC-16/MODBUS
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Frame length limits
    localparam logic [LEN_W-1:0] MIN_SPAN_FLOOR = 9'd3;
    localparam logic [LEN_W-1:0] MIN_FRAME_RST  = 9'd4;
    localparam logic [LEN_W-1:0] OUT_MAX        = 9'd511;

    // Fan-in of one level of the result tree
    localparam int unsigned RADIX = 8;

    // What one cell hands to the next
    typedef struct packed {
        logic             valid;
        logic [CRC_W-1:0] crc;
    } t_cell_link;

    // Fold one byte into a reflected CRC, one bit per step
    function automatic logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] crc,
                                                   logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/cfwf_cell.sv
module cfwf_cell #(
    parameter int unsigned SPAN = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  logic [cfwf_pkg::DATA_W-1:0]     i_byte,
    input  cfwf_pkg::t_cell_link            i_prev,
    input  logic [cfwf_pkg::LEN_W-1:0]      i_min_span,
    output cfwf_pkg::t_cell_link            o_link,
    output logic                            o_match
);

    logic                         r_valid;
    logic [cfwf_pkg::CRC_W-1:0]   r_crc;
    logic [cfwf_pkg::CRC_W-1:0]   n_crc;

    // CRC of the neighbor's start position, advanced by the new byte
    assign n_crc = cfwf_pkg::crc_fold(i_prev.crc, i_byte);

    // Occupancy moves down the row on every byte that is shifted in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_crc <= n_crc;
        end
    end

    assign o_link = '{valid: r_valid, crc: r_crc};

    // Zero residue means the trailing two bytes are the CRC of the rest
    assign o_match = r_valid && (r_crc == '0) && (32'(i_min_span) <= SPAN);

endmodule

FILE: rtl/cfwf_reduce.sv
module cfwf_reduce #(
    parameter  int unsigned N_IN  = 8,
    parameter  int unsigned CW    = 9,
    localparam int unsigned N_OUT = (N_IN + cfwf_pkg::RADIX - 1) / cfwf_pkg::RADIX
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [CW-1:0] i_cnt [N_IN],
    input  logic [CW-1:0] i_max [N_IN],
    output logic [CW-1:0] o_cnt [N_OUT],
    output logic [CW-1:0] o_max [N_OUT]
);

    // One registered sum and maximum per group of inputs
    for (genvar g = 0; g < N_OUT; g++) begin : g_grp
        localparam int unsigned BASE = g * cfwf_pkg::RADIX;
        localparam int unsigned NG   = (N_IN - BASE < cfwf_pkg::RADIX) ?
                                       (N_IN - BASE) : cfwf_pkg::RADIX;

        logic [CW-1:0] n_cnt;
        logic [CW-1:0] n_max;
        logic [CW-1:0] r_cnt;
        logic [CW-1:0] r_max;

        always_comb begin
            n_cnt = '0;
            n_max = '0;
            for (int k = 0; k < NG; k++) begin
                n_cnt = n_cnt + i_cnt[BASE + k];
                if (i_max[BASE + k] > n_max) begin
                    n_max = i_max[BASE + k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_cnt <= n_cnt;
                r_max <= n_max;
            end
        end

        assign o_cnt[g] = r_cnt;
        assign o_max[g] = r_max;
    end

endmodule

FILE: rtl/crc16_frame_window_finder_top.sv
// Channel   Dir  Bits            Fields (lowest bit first)
// s_axis    in   tdata[7:0]      data_byte
//                tuser[0]        restart
// m_axis    out  tdata[23:0]     frame_found, frame_length[8:0], match_count[8:0], zero pad
//                tuser[0]        overflow
// cfg       in   wdata[8:0]      min_frame_len, written when i_cfg_we is high
//
// One byte per cycle while m_axis is not stalled. Each byte that does not overflow the
// window shifts into the row of WINDOW CRC cells in the cycle it is taken; the per-cell
// matches pass a four-level registered tree (fan-in 8) whose last level holds the result.
// Reset (synchronous, active low) empties the window and sets min_frame_len to 4.
// Stalls on m_axis back up stage by stage; s_axis stays ready while any stage is free.
module crc16_frame_window_finder_top #(
    parameter int unsigned WINDOW = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // byte input
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [cfwf_pkg::DATA_W-1:0]          s_axis_tdata,   // data_byte
    input  logic [0:0]                           s_axis_tuser,   // restart
    // result output
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [cfwf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // found, length, count
    output logic [0:0]                           m_axis_tuser,   // overflow
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [cfwf_pkg::LEN_W-1:0]           i_cfg_wdata
);

    localparam int unsigned CW = $clog2(WINDOW + 1);
    localparam int unsigned RX = cfwf_pkg::RADIX;
    localparam int unsigned N1 = (WINDOW + RX - 1) / RX;
    localparam int unsigned N2 = (N1 + RX - 1) / RX;
    localparam int unsigned N3 = (N2 + RX - 1) / RX;
    localparam int unsigned N4 = (N3 + RX - 1) / RX;
    localparam int unsigned NS = 5;

    logic [cfwf_pkg::LEN_W-1:0] r_min_frame_len;
    logic [cfwf_pkg::LEN_W-1:0] w_min_span;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_ovf;
    logic [NS-1:0] w_mv;

    logic w_accept;
    logic w_restart;
    logic w_full;
    logic w_ovf_in;
    logic w_shift;

    cfwf_pkg::t_cell_link w_prev [WINDOW];
    cfwf_pkg::t_cell_link w_link [WINDOW];
    logic [WINDOW-1:0]    w_match;
    logic [WINDOW-1:0]    w_valid;

    logic [CW-1:0] w_cnt0 [WINDOW];
    logic [CW-1:0] w_max0 [WINDOW];
    logic [CW-1:0] w_cnt1 [N1];
    logic [CW-1:0] w_max1 [N1];
    logic [CW-1:0] w_cnt2 [N2];
    logic [CW-1:0] w_max2 [N2];
    logic [CW-1:0] w_cnt3 [N3];
    logic [CW-1:0] w_max3 [N3];
    logic [CW-1:0] w_cnt4 [N4];
    logic [CW-1:0] w_max4 [N4];

    logic [cfwf_pkg::LEN_W-1:0] w_len_sat;
    logic [cfwf_pkg::LEN_W-1:0] w_cnt_sat;
    logic [cfwf_pkg::LEN_W-1:0] w_len_out;
    logic [cfwf_pkg::LEN_W-1:0] w_cnt_out;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frame_len <= cfwf_pkg::MIN_FRAME_RST;
        end else if (i_cfg_we) begin
            r_min_frame_len <= i_cfg_wdata;
        end
    end

    assign w_min_span = (r_min_frame_len < cfwf_pkg::MIN_SPAN_FLOOR) ?
                        cfwf_pkg::MIN_SPAN_FLOOR : r_min_frame_len;

    // Stage moves: a stage loads when it is empty or its successor loads
    always_comb begin
        w_mv[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_mv[k] = !r_vld[k] || w_mv[k+1];
        end
    end

    assign s_axis_tready = w_mv[0];
    assign w_accept      = s_axis_tvalid && w_mv[0];
    assign w_restart     = s_axis_tuser[0];
    assign w_full        = w_valid[WINDOW-1];
    assign w_ovf_in      = w_full && !w_restart;
    assign w_shift       = w_accept && !w_ovf_in;

    // Beat tracking through the cell row and the tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ovf <= '0;
        end else begin
            if (w_mv[0]) begin
                r_vld[0] <= w_accept;
                r_ovf[0] <= w_ovf_in;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_mv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                    r_ovf[k] <= r_ovf[k-1];
                end
            end
        end
    end

    // Row of CRC cells; cell i holds the start position i bytes back
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_prev[i] = '{valid: 1'b1, crc: cfwf_pkg::CRC_INIT};
        end else begin : g_body
            assign w_prev[i] = '{valid: w_link[i-1].valid && !w_restart,
                                 crc:   w_link[i-1].crc};
        end

        cfwf_cell #(
            .SPAN (i + 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_shift),
            .i_byte     (s_axis_tdata),
            .i_prev     (w_prev[i]),
            .i_min_span (w_min_span),
            .o_link     (w_link[i]),
            .o_match    (w_match[i])
        );

        assign w_valid[i] = w_link[i].valid;
        assign w_cnt0[i]  = CW'(w_match[i]);
        assign w_max0[i]  = w_match[i] ? CW'(i + 1) : '0;
    end

    // Registered count and longest-span tree
    cfwf_reduce #(.N_IN(WINDOW), .CW(CW)) u_red1 (
        .i_clk (i_clk), .i_load (w_mv[1]),
        .i_cnt (w_cnt0), .i_max (w_max0), .o_cnt (w_cnt1), .o_max (w_max1)
    );

    cfwf_reduce #(.N_IN(N1), .CW(CW)) u_red2 (
        .i_clk (i_clk), .i_load (w_mv[2]),
        .i_cnt (w_cnt1), .i_max (w_max1), .o_cnt (w_cnt2), .o_max (w_max2)
    );

    cfwf_reduce #(.N_IN(N2), .CW(CW)) u_red3 (
        .i_clk (i_clk), .i_load (w_mv[3]),
        .i_cnt (w_cnt2), .i_max (w_max2), .o_cnt (w_cnt3), .o_max (w_max3)
    );

    cfwf_reduce #(.N_IN(N3), .CW(CW)) u_red4 (
        .i_clk (i_clk), .i_load (w_mv[4]),
        .i_cnt (w_cnt3), .i_max (w_max3), .o_cnt (w_cnt4), .o_max (w_max4)
    );

    // Saturate to the 9-bit fields; an ignored byte reports nothing
    assign w_len_sat = (32'(w_max4[0]) > 32'(cfwf_pkg::OUT_MAX)) ?
                       cfwf_pkg::OUT_MAX : 9'(w_max4[0]);
    assign w_cnt_sat = (32'(w_cnt4[0]) > 32'(cfwf_pkg::OUT_MAX)) ?
                       cfwf_pkg::OUT_MAX : 9'(w_cnt4[0]);
    assign w_len_out = r_ovf[NS-1] ? '0 : w_len_sat;
    assign w_cnt_out = r_ovf[NS-1] ? '0 : w_cnt_sat;

    assign m_axis_tvalid   = r_vld[NS-1];
    assign m_axis_tuser[0] = r_ovf[NS-1];
    assign m_axis_tdata    = {5'b00000, w_cnt_out, w_len_out, (w_cnt_out != '0)};

    // Checks
    a_ovf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[18:0] == '0)
        else $error("overflow beat carries a frame result");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[18:10] != '0))
        else $error("frame_found disagrees with match_count");

    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((({1'b0, w_valid} + (WINDOW + 1)'(1)) & {1'b0, w_valid}) == '0))
        else $error("window occupancy is not contiguous from the newest cell");

    a_full_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_full && !w_restart |=> r_ovf[0] && r_vld[0])
        else $error("byte into a full window not flagged");

    a_len_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[9:1] == '0) |-> m_axis_tdata[18:10] == '0)
        else $error("matches reported with zero frame length");

endmodule

FILE: verif/tb.sv
module tb;

    import cfwf_pkg::*;

    localparam int unsigned WINDOW       = 256;
    localparam int unsigned N_PHASES     = 10;
    localparam int unsigned PHASE_BYTES  = 35;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned DIR_ROWS     = 23;
    localparam int unsigned MAX_PRINTS   = 40;

    // One result beat, as the finder reports it
    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cnt;
        logic             ovf;
    } frame_res_t;

    localparam frame_res_t RES_NONE = '0;
    localparam frame_res_t RES_OVF  = '{found: 1'b0, len: '0, cnt: '0, ovf: 1'b1};

    // Directed rows: a plain byte, a byte that opens a new frame, or the CRC of the open frame
    typedef enum logic [1:0] {B_BYTE, B_START, B_CRC} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [7:0]       data;
        logic             rs;
        int unsigned      reps;
        bit               typed;
        frame_res_t       want;
    } stim_row_t;

    // Block ports
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata  = '0;    // data_byte
    logic [0:0]             s_axis_tuser  = '0;    // restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // found, length[8:0], count[8:0], pad
    logic [0:0]             m_axis_tuser;          // overflow
    logic                   i_cfg_we      = 1'b0;
    logic [LEN_W-1:0]       i_cfg_wdata   = '0;

    // Predictor state
    logic [CRC_W-1:0] win_crc [WINDOW];
    int unsigned      fill;
    logic [LEN_W-1:0] min_len;

    // Sender side
    logic [CRC_W-1:0] frame_crc;
    int unsigned      bytes_taken;
    int unsigned      tx_gap_odds;

    // Receiver side
    frame_res_t       res_q [$];
    int unsigned      rx_gap_odds  = 0;
    logic             hold_req     = 1'b0;
    logic             hold_seen    = 1'b0;
    int unsigned      hold_left    = 0;
    int unsigned      rx_left      = 0;
    int unsigned      n_beats      = 0;
    int unsigned      n_err        = 0;
    int unsigned      quiet_cycles = 0;

    stim_row_t        dir_tab [DIR_ROWS];
    logic [LEN_W-1:0] cfg_plan [N_PHASES];

    crc16_frame_window_finder_top #(
        .WINDOW(WINDOW)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Reflected CRC-16 fold of one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c, logic [7:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        return r;
    endfunction

    // Advance the window by one byte and work out the beat it should produce
    function automatic frame_res_t scan_byte(logic [7:0] b, logic rs);
        frame_res_t  r;
        int unsigned floor_len;
        int unsigned longest;
        int unsigned hits;
        r         = RES_NONE;
        floor_len = (min_len < MIN_SPAN_FLOOR) ? 32'(MIN_SPAN_FLOOR) : 32'(min_len);
        longest   = 0;
        hits      = 0;
        if (rs) begin
            fill = 0;
        end
        // full window: byte dropped
        if (fill >= WINDOW) begin
            r.ovf = 1'b1;
            return r;
        end
        win_crc[fill] = CRC_INIT;
        fill++;
        for (int unsigned s = 0; s < fill; s++) begin
            win_crc[s] = crc_step(win_crc[s], b);
            if (win_crc[s] == '0 && fill - s >= floor_len) begin
                hits++;
                if (fill - s > longest) begin
                    longest = fill - s;
                end
            end
        end
        if (longest > 32'(OUT_MAX)) longest = 32'(OUT_MAX);
        if (hits > 32'(OUT_MAX)) hits = 32'(OUT_MAX);
        r.found = (hits != 0);
        r.len   = longest[LEN_W-1:0];
        r.cnt   = hits[LEN_W-1:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 12;
        endcase
    endfunction

    task automatic report(string field, int unsigned got, int unsigned want_v);
        if (n_err < MAX_PRINTS) begin
            $display("mismatch at beat %0d: %s got %0d want %0d", n_beats, field, got, want_v);
        end
        n_err++;
    endtask

    // Compare one output beat against the oldest expectation
    task automatic check_beat();
        frame_res_t want;
        if (res_q.size() == 0) begin
            report("unexpected beat", 32'(m_axis_tdata), 0);
        end else begin
            want = res_q.pop_front();
            if (m_axis_tdata[0] !== want.found)
                report("frame_found", 32'(m_axis_tdata[0]), 32'(want.found));
            if (m_axis_tdata[9:1] !== want.len)
                report("frame_length", 32'(m_axis_tdata[9:1]), 32'(want.len));
            if (m_axis_tdata[18:10] !== want.cnt)
                report("match_count", 32'(m_axis_tdata[18:10]), 32'(want.cnt));
            if (m_axis_tuser[0] !== want.ovf)
                report("overflow", 32'(m_axis_tuser[0]), 32'(want.ovf));
        end
        n_beats++;
    endtask

    // Offer one byte, wait for it to be taken, then predict its beat
    task automatic put_beat(logic [7:0] d, logic rs, logic opens, bit typed, frame_res_t want);
        frame_res_t r;
        if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= d;
        s_axis_tuser[0] <= rs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (rs || opens) frame_crc = CRC_INIT;
        frame_crc = crc_step(frame_crc, d);
        r = scan_byte(d, rs);
        if (!r.ovf) bytes_taken++;
        res_q.push_back(typed ? want : r);
    endtask

    // Close the open frame with its CRC, low byte first; optionally spoil it
    task automatic send_crc(bit broken);
        logic [CRC_W-1:0] c;
        logic [7:0]       flip;
        c    = frame_crc;
        flip = broken ? 8'($urandom_range(1, 255)) : 8'h00;
        put_beat(c[7:0] ^ flip, 1'b0, 1'b0, 1'b0, RES_NONE);
        put_beat(c[15:8], 1'b0, 1'b0, 1'b0, RES_NONE);
    endtask

    task automatic send_frame(logic rs, int unsigned plen, bit broken);
        put_beat(8'($urandom), rs, 1'b1, 1'b0, RES_NONE);
        for (int unsigned k = 1; k < plen; k++) begin
            put_beat(8'($urandom), 1'b0, 1'b0, 1'b0, RES_NONE);
        end
        send_crc(broken);
    endtask

    // One buffer filling most of the window, then trailing bytes that may overflow it
    task automatic send_long(int unsigned plen, int unsigned extra);
        send_frame(1'b1, plen, 1'b0);
        repeat (extra) put_beat(8'($urandom), 1'b0, 1'b0, 1'b0, RES_NONE);
    endtask

    // Mostly back-to-back valid frames, some long buffers, some plain noise
    task automatic send_random_buffer();
        int unsigned pick;
        int unsigned nfr;
        int unsigned plen;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            nfr = $urandom_range(1, 4);
            for (int unsigned f = 0; f < nfr; f++) begin
                if (f != 0 && $urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3))
                        put_beat(8'($urandom), 1'b0, 1'b0, 1'b0, RES_NONE);
                end
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 10);
                send_frame(f == 0, plen, $urandom_range(0, 9) == 0);
            end
        end else if (pick < 75) begin
            send_long($urandom_range(0, 1) ? 254 : $urandom_range(180, 254),
                      $urandom_range(0, 12));
        end else begin
            repeat ($urandom_range(1, 24))
                put_beat(8'($urandom), $urandom_range(0, 9) == 0, 1'b0, 1'b0, RES_NONE);
        end
    endtask

    // Stop offering and let every outstanding beat drain
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (res_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [LEN_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        min_len      = v;
        @(posedge i_clk);
    endtask

    // Result side: checking and backpressure
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) check_beat();
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap_odds != 0 && $urandom_range(1, rx_gap_odds) == 1) begin
            rx_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        fill        = 0;
        min_len     = MIN_FRAME_RST;
        frame_crc   = CRC_INIT;
        bytes_taken = 0;
        tx_gap_odds = 0;

        dir_tab = '{
            // lone first byte after reset: span too short to match
            '{B_START, 8'h01, 1'b1, 1,   1'b1, RES_NONE},
            // classic read-holding-registers request with its CRC
            '{B_BYTE,  8'h03, 1'b0, 1,   1'b0, RES_NONE},
            '{B_BYTE,  8'h00, 1'b0, 3,   1'b0, RES_NONE},
            '{B_BYTE,  8'h01, 1'b0, 1,   1'b0, RES_NONE},
            '{B_BYTE,  8'h84, 1'b0, 1,   1'b0, RES_NONE},
            '{B_BYTE,  8'h0A, 1'b0, 1,   1'b0, RES_NONE},
            // three-byte frame, below the reset minimum of four
            '{B_START, 8'hFF, 1'b1, 1,   1'b0, RES_NONE},
            '{B_CRC,   8'h00, 1'b0, 1,   1'b0, RES_NONE},
            // second frame opened mid-buffer
            '{B_START, 8'h00, 1'b0, 1,   1'b0, RES_NONE},
            '{B_CRC,   8'h00, 1'b0, 1,   1'b0, RES_NONE},
            // extreme byte values
            '{B_START, 8'h80, 1'b1, 1,   1'b0, RES_NONE},
            '{B_BYTE,  8'h7F, 1'b0, 1,   1'b0, RES_NONE},
            '{B_BYTE,  8'hFF, 1'b0, 1,   1'b0, RES_NONE},
            '{B_BYTE,  8'h00, 1'b0, 1,   1'b0, RES_NONE},
            '{B_CRC,   8'h00, 1'b0, 1,   1'b0, RES_NONE},
            '{B_START, 8'h55, 1'b0, 1,   1'b0, RES_NONE},
            '{B_BYTE,  8'hAA, 1'b0, 1,   1'b0, RES_NONE},
            '{B_CRC,   8'h00, 1'b0, 1,   1'b0, RES_NONE},
            // fill the window, then bytes past the end are dropped
            '{B_START, 8'hFF, 1'b1, 256, 1'b0, RES_NONE},
            '{B_BYTE,  8'h00, 1'b0, 1,   1'b1, RES_OVF},
            '{B_BYTE,  8'hFF, 1'b0, 1,   1'b1, RES_OVF},
            // restart on a full window starts over instead of overflowing
            '{B_START, 8'hA5, 1'b1, 1,   1'b1, RES_NONE},
            '{B_CRC,   8'h00, 1'b0, 1,   1'b0, RES_NONE}
        };

        cfg_plan = '{9'd3, 9'd0, 9'd256, 9'd511, 9'd257, 9'd1, 9'd9, 9'd0, 9'd8, 9'd4};
        cfg_plan[7] = 9'($urandom_range(0, 511));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset minimum
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == B_CRC) begin
                send_crc(1'b0);
            end else begin
                for (int unsigned k = 0; k < dir_tab[i].reps; k++) begin
                    put_beat(dir_tab[i].data, dir_tab[i].rs && k == 0,
                             dir_tab[i].kind == B_START && k == 0,
                             dir_tab[i].typed, dir_tab[i].want);
                end
            end
        end

        // Random part, one minimum-length setting per phase
        for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
            int unsigned goal;
            write_cfg(cfg_plan[ph]);
            if (ph >= N_PHASES - 2) begin
                tx_gap_odds  = 0;
                rx_gap_odds <= 0;
            end else begin
                tx_gap_odds  = pick_gap_odds();
                rx_gap_odds <= pick_gap_odds();
            end
            // long result-side hold while bytes keep coming
            if (ph == 1) hold_req <= ~hold_req;
            // a frame spanning the whole window, then overflow
            if (cfg_plan[ph] >= 9'd256) send_long(254, 3);
            goal = bytes_taken + PHASE_BYTES;
            while (bytes_taken < goal) send_random_buffer();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: crc16_frame_window_finder_top.f
rtl/cfwf_pkg.sv
rtl/cfwf_cell.sv
rtl/cfwf_reduce.sv
rtl/crc16_frame_window_finder_top.sv
verif/tb.sv
